// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/rv32i_pkg.sv -----
`default_nettype none
package rv32i_pkg;

  typedef struct packed {
    logic        kind;
    logic [11:0] load_word_index;
    logic [31:0] load_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pc_after;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic [1:0]  ecall_service;
    logic [31:0] ecall_argument;
    logic        halted;
  } out_item_t;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_ALUI   = 7'h13;
  localparam logic [6:0] OP_ALU    = 7'h33;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [31:0] PC_FINAL = 32'd8000;

  localparam logic [1:0] SVC_NONE  = 2'd0;
  localparam logic [1:0] SVC_INT   = 2'd1;
  localparam logic [1:0] SVC_STR   = 2'd2;
  localparam logic [1:0] SVC_EXIT  = 2'd3;

  localparam logic [31:0] A7_INT  = 32'd1;
  localparam logic [31:0] A7_STR  = 32'd4;
  localparam logic [31:0] A7_EXIT = 32'd10;

  localparam logic [4:0] REG_A0 = 5'd10;
  localparam logic [4:0] REG_A7 = 5'd17;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_MEM   = 4'b1000
  } state_e;

  // Request from sequencer to memory
  typedef struct packed {
    logic        we;
    logic [31:0] wdata;
  } mem_wr_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rv32i_wmem.sv -----
`default_nettype none
module rv32i_wmem
  import rv32i_pkg::*;
#(
  parameter int unsigned MemWords = 4096,
  localparam int unsigned AW = $clog2(MemWords)
) (
  input  wire logic          clk_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire mem_wr_t       wr_i,
  output logic [31:0]        rdata_o
);

  logic [31:0] mem_q [MemWords];

  // Single-port word memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[addr_i] <= wr_i.wdata;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rv32i_regfile.sv -----
`default_nettype none
module rv32i_regfile
  import rv32i_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [4:0]  ra_i,
  input  wire logic [4:0]  rb_i,
  input  wire logic        we_i,
  input  wire logic [4:0]  wa_i,
  input  wire logic [31:0] wd_i,
  output logic [31:0]      a_o,
  output logic [31:0]      b_o,
  output logic [31:0]      a0_o,
  output logic [31:0]      a7_o
);

  // Two-read memory with reset-time valid bits; x0 never valid
  logic [31:0] ram_a_q [32];
  logic [31:0] ram_b_q [32];
  logic [31:0] vld_q;
  logic [31:0] rda_q, rdb_q;
  logic        va_q, vb_q;
  logic [31:0] a0_q, a7_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      ram_a_q[wa_i] <= wd_i;
      ram_b_q[wa_i] <= wd_i;
    end
    rda_q <= ram_a_q[ra_i];
    rdb_q <= ram_b_q[rb_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      va_q  <= 1'b0;
      vb_q  <= 1'b0;
      a0_q  <= '0;
      a7_q  <= '0;
    end else begin
      va_q <= vld_q[ra_i];
      vb_q <= vld_q[rb_i];
      if (we_i && wa_i != 5'd0) begin
        vld_q[wa_i] <= 1'b1;
        if (wa_i == REG_A0) a0_q <= wd_i;
        if (wa_i == REG_A7) a7_q <= wd_i;
      end
    end
  end

  assign a_o  = va_q ? rda_q : 32'd0;
  assign b_o  = vb_q ? rdb_q : 32'd0;
  assign a0_o = a0_q;
  assign a7_o = a7_q;

endmodule
`default_nettype wire

// ----- hw/rtl/rv32i_instruction_step_core.sv -----
// rv32i_instruction_step_core: RV32I instruction step engine with its own
// word memory. Input channel (in_valid_i/in_ready_o, in_item_i) carries
// either a memory preload (kind=1) or one instruction step (kind=0).
// Output channel (out_valid_o/out_ready_i, out_item_o) returns exactly one
// result per input transaction.
// Steps, from the accept cycle on: a preload or a step after halt is
// accepted in idle and finishes in the memory state; a step is accepted
// with its fetch read, reads the register file in fetch and finishes in
// execute; a load or store goes on to the memory state, since it needs a
// second access to the single-port word memory. The result register is
// separate, so a new transaction is taken while a result waits; the next
// transaction waits only if the result register is still full when it
// finishes. A new transaction is accepted only in idle, once the last one
// has finished.
// Reset clears pc, halt flag and register file valid bits; the word memory
// is undefined until preloaded. While the receiver stalls the result is held
// and at most one further transaction is accepted and parked in its work.
`default_nettype none
`include "assert_macros.svh"
module rv32i_instruction_step_core
  import rv32i_pkg::*;
#(
  parameter int unsigned MEM_WORDS = 4096
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  state_e      state_q, state_d;
  logic [31:0] pc_q, pc_d;
  logic        halt_q, halt_d;
  logic [31:0] ir_q;
  logic [31:0] ea_q;
  logic [4:0]  ld_rd_q;
  logic [2:0]  ld_f3_q;
  logic        ld_q;
  logic        st_q;
  logic        out_valid_q;
  out_item_t   out_q;
  logic        res_ok;
  logic        push;
  out_item_t   res;

  // memory port
  logic [AW-1:0] maddr;
  mem_wr_t       mwr;
  logic [31:0]   mrdata;

  rv32i_wmem #(.MemWords(MEM_WORDS)) u_wmem (
    .clk_i  (clk_i),
    .addr_i (maddr),
    .wr_i   (mwr),
    .rdata_o(mrdata)
  );

  // register file; source fields come from the fetched word, then from ir_q
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;
  logic [31:0] ra, rb, a0v, a7v;
  logic [4:0]  rs1_sel, rs2_sel;

  assign rs1_sel = (state_q == ST_FETCH) ? mrdata[19:15] : ir_q[19:15];
  assign rs2_sel = (state_q == ST_FETCH) ? mrdata[24:20] : ir_q[24:20];

  rv32i_regfile u_rf (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ra_i  (rs1_sel),
    .rb_i  (rs2_sel),
    .we_i  (rf_we),
    .wa_i  (rf_wa),
    .wd_i  (rf_wd),
    .a_o   (ra),
    .b_o   (rb),
    .a0_o  (a0v),
    .a7_o  (a7v)
  );

  // decode of the held instruction
  logic [6:0]  op, f7;
  logic [2:0]  f3;
  logic [4:0]  rd;
  logic [31:0] sgn, imm_i, imm_s, imm_b, imm_j, upper;
  assign op    = ir_q[6:0];
  assign rd    = ir_q[11:7];
  assign f3    = ir_q[14:12];
  assign f7    = ir_q[31:25];
  assign sgn   = {32{ir_q[31]}};
  assign imm_i = {sgn[31:12], ir_q[31:20]};
  assign imm_s = {sgn[31:12], ir_q[31:25], ir_q[11:7]};
  assign imm_b = {sgn[31:12], ir_q[7], ir_q[30:25], ir_q[11:8], 1'b0};
  assign imm_j = {sgn[31:20], ir_q[19:12], ir_q[20], ir_q[30:21], 1'b0};
  assign upper = {ir_q[31:12], 12'd0};

  // ALU
  logic [31:0] opb, alu_res;
  logic [4:0]  shamt;
  logic        alu_ok, lts, ltu;
  assign opb   = (op == OP_ALUI) ? imm_i : rb;
  assign shamt = (op == OP_ALUI) ? ir_q[24:20] : rb[4:0];
  assign lts   = $signed(ra) < $signed(opb);
  assign ltu   = ra < opb;

  always_comb begin
    alu_ok  = 1'b1;
    alu_res = '0;
    case (f3)
      3'd0: begin
        if (op == OP_ALUI || f7 == F7_BASE) alu_res = ra + opb;
        else if (f7 == F7_ALT) alu_res = ra - opb;
        else alu_ok = 1'b0;
      end
      3'd1: alu_res = ra << shamt;
      3'd2: alu_res = {31'd0, lts};
      3'd3: alu_res = {31'd0, ltu};
      3'd4: alu_res = ra ^ opb;
      3'd5: begin
        if (f7 == F7_BASE) alu_res = ra >> shamt;
        else if (f7 == F7_ALT) alu_res = $unsigned($signed(ra) >>> shamt);
        else alu_ok = 1'b0;
      end
      3'd6: alu_res = ra | opb;
      default: alu_res = ra & opb;
    endcase
  end

  // branch condition
  logic take;
  always_comb begin
    case (f3)
      3'd0: take = (ra == rb);
      3'd1: take = (ra != rb);
      3'd4: take = $signed(ra) < $signed(rb);
      3'd5: take = !($signed(ra) < $signed(rb));
      3'd6: take = ra < rb;
      3'd7: take = ra >= rb;
      default: take = 1'b0;
    endcase
  end

  // execute-stage results
  logic [31:0] ex_pc, ex_val, ea_ld, ea_st;
  logic        ex_wr;
  logic [1:0]  ex_svc;
  logic        is_ld, is_st;
  assign ea_ld = ra + imm_i;
  assign ea_st = ra + imm_s;
  assign is_ld = (op == OP_LOAD) && (f3 == 3'd0 || f3 == 3'd2 || f3 == 3'd4);
  assign is_st = (op == OP_STORE) && (f3 == 3'd0 || f3 == 3'd2);

  always_comb begin
    ex_pc  = pc_q;
    ex_val = '0;
    ex_wr  = 1'b0;
    ex_svc = SVC_NONE;
    unique case (op)
      OP_LUI:   begin ex_val = upper; ex_wr = 1'b1; end
      OP_AUIPC: begin ex_val = pc_q - 32'd4 + upper; ex_wr = 1'b1; end
      OP_JAL: begin
        ex_val = pc_q; ex_wr = 1'b1; ex_pc = pc_q - 32'd4 + imm_j;
      end
      OP_JALR: begin
        ex_val = pc_q; ex_wr = 1'b1; ex_pc = (ra + imm_i) & ~32'd1;
      end
      OP_BRANCH: if (take) ex_pc = pc_q - 32'd4 + imm_b;
      OP_ALUI, OP_ALU: begin ex_val = alu_res; ex_wr = alu_ok; end
      OP_SYSTEM: begin
        if (a7v == A7_INT) ex_svc = SVC_INT;
        else if (a7v == A7_STR) ex_svc = SVC_STR;
        else if (a7v == A7_EXIT) ex_svc = SVC_EXIT;
      end
      default: ;
    endcase
  end

  // load data extraction
  logic [7:0]  ld_byte;
  logic [31:0] ld_val;
  assign ld_byte = mrdata[{ea_q[1:0], 3'd0} +: 8];
  always_comb begin
    case (ld_f3_q)
      3'd0:    ld_val = {{24{ld_byte[7]}}, ld_byte};
      3'd2:    ld_val = mrdata;
      default: ld_val = {24'd0, ld_byte};
    endcase
  end

  // store merge
  logic [31:0] st_word;
  always_comb begin
    st_word = mrdata;
    if (ld_f3_q == 3'd2) st_word = ir_q;
    else st_word[{ea_q[1:0], 3'd0} +: 8] = ir_q[7:0];
  end

  // result slot free if empty or draining this cycle
  assign res_ok     = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  // sequencer
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    halt_d  = halt_q;
    maddr   = pc_q[AW+1:2];
    mwr     = '{we: 1'b0, wdata: in_item_i.load_word};
    rf_we   = 1'b0;
    rf_wa   = rd;
    rf_wd   = ex_val;
    push    = 1'b0;
    res     = '0;
    res.pc_after = pc_q;
    res.halted   = halt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_item_i.kind) begin
            maddr  = AW'(in_item_i.load_word_index);
            mwr.we = 1'b1;
            state_d = ST_MEM;
          end else if (halt_q) begin
            state_d = ST_MEM;
          end else begin
            state_d = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        pc_d    = pc_q + 32'd4;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (is_ld || is_st) begin
          maddr = is_ld ? ea_ld[AW+1:2] : ea_st[AW+1:2];
          state_d = ST_MEM;
        end else if (res_ok) begin
          pc_d  = ex_pc;
          rf_we = ex_wr && rd != 5'd0;
          if (ex_svc == SVC_EXIT || ex_pc == PC_FINAL) halt_d = 1'b1;
          push = 1'b1;
          res.pc_after       = ex_pc;
          res.reg_write      = rf_we;
          res.reg_index      = rf_we ? rd : 5'd0;
          res.reg_value      = rf_we ? ex_val : 32'd0;
          res.ecall_service  = ex_svc;
          res.ecall_argument = (ex_svc != SVC_NONE) ? a0v : 32'd0;
          res.halted         = halt_d;
          state_d = ST_IDLE;
        end
      end
      ST_MEM: begin
        // also finishes preload and halted no-op transactions
        maddr = ea_q[AW+1:2];
        if (res_ok) begin
          push = 1'b1;
          if (ld_q && !halt_q) begin
            rf_we = ld_rd_q != 5'd0;
            rf_wa = ld_rd_q;
            rf_wd = ld_val;
            res.reg_write = rf_we;
            res.reg_index = rf_we ? ld_rd_q : 5'd0;
            res.reg_value = rf_we ? ld_val : 32'd0;
          end else if (!halt_q && st_q) begin
            mwr.we    = 1'b1;
            mwr.wdata = st_word;
          end
          if (!halt_q && (ld_q || st_q) && pc_q == PC_FINAL) halt_d = 1'b1;
          res.halted = halt_d;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      halt_q      <= 1'b0;
      out_valid_q <= 1'b0;
      ld_q        <= 1'b0;
      st_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      halt_q  <= halt_d;
      if (push) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (state_q == ST_IDLE) begin
        ld_q <= 1'b0;
        st_q <= 1'b0;
      end else if (state_q == ST_EXEC) begin
        ld_q <= is_ld;
        st_q <= is_st;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (push) out_q <= res;
    if (state_q == ST_FETCH) ir_q <= mrdata;
    if (state_q == ST_EXEC) begin
      ea_q    <= is_ld ? ea_ld : ea_st;
      ld_rd_q <= rd;
      ld_f3_q <= f3;
      if (is_st) ir_q <= rb;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // checks
  `ASSERT_IMPL(a_push_slot, clk_i, rst_ni, push, res_ok)
  `ASSERT_NEXT(a_push_valid, clk_i, rst_ni, push, out_valid_o)
  `ASSERT_NEXT(a_halt_sticky, clk_i, rst_ni, halt_q, halt_q)
  `ASSERT_IMPL(a_one_access, clk_i, rst_ni, mwr.we, state_q == ST_IDLE || state_q == ST_MEM)

endmodule
`default_nettype wire
